// ===== hw/rtl/pcts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcts_pkg;

    localparam int TASK_COUNT = 8;
    localparam int COUNT_BITS = 4;
    localparam int IDX_BITS   = $clog2(TASK_COUNT);
    localparam int MASK_BITS  = 8;

    localparam logic [MASK_BITS-1:0] MASK_RESET = MASK_BITS'(254);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic                latch;
        logic                check;
        logic                clr_scan;
        logic                scan;
        logic                reload;
        logic                set_rel;
        logic                set_none;
        logic                commit;
        logic                finish;
        logic [IDX_BITS-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic need_sched;
        logic found;
        logic top_zero;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/pcts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcts_ctrl
    import pcts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_RELOAD,
        S_COMMIT,
        S_FINISH
    } t_state;

    localparam logic [IDX_BITS-1:0] IDX_TOP  = IDX_BITS'(TASK_COUNT - 1);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(1);

    t_state              r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check    = 1'b1;
                o_cmd.clr_scan = 1'b1;
                n_idx          = IDX_TOP;
                n_state        = i_sts.need_sched ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_idx      = r_idx - IDX_BITS'(1);
                if (r_idx == IDX_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx = IDX_TOP;
                if (!i_sts.found) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_sts.top_zero) begin
                    o_cmd.set_rel  = 1'b1;
                    o_cmd.clr_scan = 1'b1;
                    n_state        = S_RELOAD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_RELOAD: begin
                o_cmd.reload = 1'b1;
                n_idx        = r_idx - IDX_BITS'(1);
                if (r_idx == IDX_LAST) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcts_dp
    import pcts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_cfg_we,
    input  wire logic [MASK_BITS-1:0]  i_cfg_data,
    input  wire logic                  i_opcode,
    input  wire logic [IDX_BITS-1:0]   i_task_index,
    input  wire logic [COUNT_BITS-1:0] i_priority_value,
    output logic                       o_result_valid,
    output logic [IDX_BITS-1:0]        o_running_task,
    output logic                       o_switched,
    output logic                       o_reloaded,
    output logic [COUNT_BITS-1:0]      o_running_counter,
    output logic                       o_no_task
);

    logic [COUNT_BITS-1:0] r_cnt  [TASK_COUNT];
    logic [COUNT_BITS-1:0] r_prio [TASK_COUNT];
    logic [MASK_BITS-1:0]  r_mask;
    logic [IDX_BITS-1:0]   r_cur;

    logic                  r_op;
    logic [IDX_BITS-1:0]   r_tidx;
    logic [COUNT_BITS-1:0] r_pval;

    logic                  r_found;
    logic [COUNT_BITS-1:0] r_top;
    logic [IDX_BITS-1:0]   r_chosen;
    logic                  r_sw, r_rel, r_none;

    logic [IDX_BITS-1:0]   rd_addr;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [COUNT_BITS-1:0] prio_rd;
    logic [COUNT_BITS-1:0] cand;
    logic                  slot_en;
    logic                  take;
    logic                  cur_live;

    assign rd_addr  = (i_cmd.scan || i_cmd.reload) ? i_cmd.idx : r_cur;
    assign cnt_rd   = r_cnt[rd_addr];
    assign prio_rd  = r_prio[i_cmd.idx];
    assign cand     = i_cmd.reload ? prio_rd : cnt_rd;
    assign slot_en  = (i_cmd.idx != '0) && r_mask[i_cmd.idx];
    assign take     = slot_en && (!r_found || (cand > r_top));
    assign cur_live = (r_cur != '0) && (cnt_rd != '0);

    assign o_sts.need_sched = (r_op == OP_TICK) &&
                              (!cur_live || (cnt_rd == COUNT_BITS'(1)));
    assign o_sts.found      = r_found;
    assign o_sts.top_zero   = (r_top == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_cnt[i]  <= '0;
                r_prio[i] <= '0;
            end
            r_mask         <= MASK_RESET;
            r_cur          <= '0;
            o_result_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            if (i_cmd.latch) begin
                r_op   <= i_opcode;
                r_tidx <= i_task_index;
                r_pval <= i_priority_value;
                r_sw   <= 1'b0;
                r_rel  <= 1'b0;
                r_none <= 1'b0;
            end
            if (i_cmd.check) begin
                if (r_op == OP_LOAD) begin
                    r_prio[r_tidx] <= r_pval;
                end else if (cur_live) begin
                    r_cnt[r_cur] <= cnt_rd - COUNT_BITS'(1);
                end
            end
            if (i_cmd.clr_scan) begin
                r_found <= 1'b0;
                r_top   <= '0;
            end
            if ((i_cmd.scan || i_cmd.reload) && take) begin
                r_found  <= 1'b1;
                r_top    <= cand;
                r_chosen <= i_cmd.idx;
            end
            if (i_cmd.reload && slot_en) begin
                r_cnt[i_cmd.idx] <= prio_rd;
            end
            if (i_cmd.set_rel) begin
                r_rel <= 1'b1;
            end
            if (i_cmd.set_none) begin
                r_none <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_cur <= r_chosen;
                r_sw  <= (r_chosen != r_cur);
            end
            o_result_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                o_running_task    <= r_cur;
                o_switched        <= r_sw;
                o_reloaded        <= r_rel;
                o_running_counter <= cnt_rd;
                o_no_task         <= r_none;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_counter_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Payload
// command   in         i_start, o_busy                i_opcode, i_task_index, i_priority_value
// result    out        o_result_valid (one cycle)     o_running_task, o_switched, o_reloaded,
//                                                     o_running_counter, o_no_task
// config    in         i_cfg_valid, o_cfg_ready       i_cfg_data (task enable mask)
//
// Between accepting an item and showing its result, a load item or a tick that does not
// schedule passes through the check and finish states. A scheduling tick adds a scan over
// slots 7 down to 1 plus a decide and a commit state; with no enabled task, commit is skipped.
// When all enabled counters are zero, a refill and rescan of those slots comes before commit.
// Reset is synchronous and active low; it clears all counters, priorities and the running task.
// The receiver cannot stall; a new item may be accepted in the cycle that shows the result.

module priority_counter_task_scheduler
    import pcts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [0:0]            i_opcode,
    input  wire logic [IDX_BITS-1:0]   i_task_index,
    input  wire logic [COUNT_BITS-1:0] i_priority_value,
    output logic                       o_result_valid,
    output logic [IDX_BITS-1:0]        o_running_task,
    output logic                       o_switched,
    output logic                       o_reloaded,
    output logic [COUNT_BITS-1:0]      o_running_counter,
    output logic                       o_no_task,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [MASK_BITS-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    busy;

    assign o_busy      = busy;
    assign o_cfg_ready = !busy;

    pcts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pcts_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid && !busy),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode[0]),
        .i_task_index      (i_task_index),
        .i_priority_value  (i_priority_value),
        .o_result_valid    (o_result_valid),
        .o_running_task    (o_running_task),
        .o_switched        (o_switched),
        .o_reloaded        (o_reloaded),
        .o_running_counter (o_running_counter),
        .o_no_task         (o_no_task)
    );

endmodule

`default_nettype wire
